// ===== sv/pafk_pkg.sv =====
// Package for the planar arm forward kinematics block.
// Holds widths, the rotation angle table, the state codes and the command struct.
// No dependencies.
package pafk_pkg;

   // Field and register widths
   localparam int ANGLE_W      = 16;
   localparam int POS_W        = 20;
   localparam int LINK_LEN_W   = 16;
   localparam int LINK_IDX_W   = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_LINK_REGS = 6;
   localparam logic [LINK_LEN_W-1:0] LINK_LEN_RESET = 16'd256;

   // Rotation unit: Q4.30 values, angles in units of 2^-32 turn
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 4;
   localparam int TRIG_W       = 16;
   localparam int PROD_W       = 33;

   localparam logic signed [CORDIC_W-1:0] CORDIC_X_INIT = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN  = 34'sd1073741824;
   localparam logic signed [CORDIC_W-1:0] HALF_TURN     = 34'sd2147483648;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic signed [CORDIC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
      34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
      34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
      34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D
   };

   // Controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_ROTATE  = 7'b0000010,
      ST_TRIG    = 7'b0000100,
      ST_SCALE_X = 7'b0001000,
      ST_SCALE_Y = 7'b0010000,
      ST_ACC_Y   = 7'b0100000,
      ST_DELIVER = 7'b1000000
   } pafk_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic              start;
      logic              rotate;
      logic [STEP_W-1:0] step;
      logic              trig;
      logic              scale_x;
      logic              scale_y;
      logic              acc_y;
      logic              deliver;
   } pafk_cmd_type;

endpackage

// ===== sv/pafk_if.sv =====
// Request and response channel interfaces for the planar arm block.
// Valid/ready handshake with payload; no dependencies.
interface pafk_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] joint_angle;
   logic               last_joint;

   modport source (output valid, output joint_angle, output last_joint, input ready);
   modport sink   (input valid, input joint_angle, input last_joint, output ready);
endinterface

interface pafk_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         link_index;
   logic signed [19:0] end_x;
   logic signed [19:0] end_y;
   logic               chain_done;

   modport source (output valid, output link_index, output end_x, output end_y,
                   output chain_done, input ready);
   modport sink   (input valid, input link_index, input end_x, input end_y,
                   input chain_done, output ready);
endinterface

// ===== sv/planar_arm_forward_kinematics.sv =====
// Planar serial arm forward kinematics: one joint angle in, one link end point out.
// After a request is accepted the block runs 16 rotation steps, one trig step, two multiply
// steps and one accumulate step, then loads the result register once the output slot is free.
// A new request is taken only after the last one is delivered; the 16-step shift-add sine/cosine loop is not pipelined.
// Synchronous active-high reset clears the chain state and sets link lengths to 1.0.
// Depends on pafk_pkg, pafk_if, pafk_ctrl and pafk_dp.
module planar_arm_forward_kinematics #(
   parameter int N_JOINTS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   pafk_req_if.sink                          req_ch,
   pafk_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [pafk_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pafk_pkg::LINK_LEN_W-1:0]   csr_write_data
);
   import pafk_pkg::*;

   pafk_cmd_type cmd;

   // Sequence each request
   pafk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Compute the link end point
   pafk_dp #(
      .N_JOINTS (N_JOINTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .joint_angle    (req_ch.joint_angle),
      .last_joint     (req_ch.last_joint),
      .link_index     (rsp_ch.link_index),
      .end_x          (rsp_ch.end_x),
      .end_y          (rsp_ch.end_y),
      .chain_done     (rsp_ch.chain_done)
   );

endmodule

// ===== sv/pafk_ctrl.sv =====
// Controller for the planar arm block: sequences accept, rotation, scaling and delivery.
// Depends on pafk_pkg for state codes and the command struct.
module pafk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pafk_pkg::pafk_cmd_type cmd
);
   import pafk_pkg::*;

   pafk_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;
   logic              accept;

   // Output slot frees when empty or when its response is taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_ROTATE;
         ST_ROTATE:  if (step_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_TRIG;
         ST_TRIG:    state_in = ST_SCALE_X;
         ST_SCALE_X: state_in = ST_SCALE_Y;
         ST_SCALE_Y: state_in = ST_ACC_Y;
         ST_ACC_Y:   state_in = ST_DELIVER;
         ST_DELIVER: if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Rotation step counter: clear on accept, advance each rotation cycle
   always_comb begin
      step_in = step_ff;
      if (accept) begin
         step_in = '0;
      end else if (state_ff == ST_ROTATE) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Hold the result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.start   = accept;
      cmd.rotate  = (state_ff == ST_ROTATE);
      cmd.step    = step_ff;
      cmd.trig    = (state_ff == ST_TRIG);
      cmd.scale_x = (state_ff == ST_SCALE_X);
      cmd.scale_y = (state_ff == ST_SCALE_Y);
      cmd.acc_y   = (state_ff == ST_ACC_Y);
      cmd.deliver = (state_ff == ST_DELIVER) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/pafk_dp.sv =====
// Datapath for the planar arm block: link length registers, angle and tip
// accumulators, shift-add sine/cosine unit, shared multiplier and result register.
// Depends on pafk_pkg.
module pafk_dp #(
   parameter int N_JOINTS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pafk_pkg::pafk_cmd_type               cmd,
   input  logic                                 csr_write_en,
   input  logic [pafk_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pafk_pkg::LINK_LEN_W-1:0]      csr_write_data,
   input  logic [pafk_pkg::ANGLE_W-1:0]         joint_angle,
   input  logic                                 last_joint,
   output logic [pafk_pkg::LINK_IDX_W-1:0]      link_index,
   output logic signed [pafk_pkg::POS_W-1:0]    end_x,
   output logic signed [pafk_pkg::POS_W-1:0]    end_y,
   output logic                                 chain_done
);
   import pafk_pkg::*;

   logic [LINK_LEN_W-1:0]       link_len_ff [NUM_LINK_REGS];
   logic [ANGLE_W-1:0]          angle_total_ff;
   logic signed [POS_W-1:0]     tip_x_ff, tip_y_ff;
   logic [LINK_IDX_W-1:0]       link_count_ff;
   logic                        last_ff;

   logic signed [CORDIC_W-1:0]  x_ff, y_ff, z_ff;
   logic                        flip_ff;
   logic signed [TRIG_W-1:0]    cos_ff, sin_ff;
   logic signed [PROD_W-1:0]    prod_ff;

   logic [LINK_IDX_W-1:0]       out_index_ff;
   logic signed [POS_W-1:0]     out_x_ff, out_y_ff;
   logic                        out_done_ff;

   logic [ANGLE_W-1:0]          angle_in;
   logic signed [CORDIC_W-1:0]  z_raw, z_fold;
   logic                        flip_in;
   logic signed [CORDIC_W-1:0]  x_sh, y_sh, x_neg, y_neg;
   logic [LINK_LEN_W-1:0]       len_sel;
   logic signed [TRIG_W-1:0]    trig_sel;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-16:0]   prod_q;
   logic signed [POS_W-1:0]     tip_step;
   logic                        done;

   // Floor a Q4.30 value to Q1.15 and saturate
   function automatic logic signed [TRIG_W-1:0] sat_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] r;
      r = v >>> 15;
      if (r > 34'sd32767) begin
         sat_q15 = 16'sh7FFF;
      end else if (r < -34'sd32768) begin
         sat_q15 = 16'sh8000;
      end else begin
         sat_q15 = r[TRIG_W-1:0];
      end
   endfunction

   // New angle sum and fold into the right half plane
   assign angle_in = angle_total_ff + joint_angle;
   assign z_raw    = {{2{angle_in[ANGLE_W-1]}}, angle_in, 16'h0000};
   always_comb begin
      z_fold  = z_raw;
      flip_in = 1'b0;
      if (z_raw > QUARTER_TURN) begin
         z_fold  = z_raw - HALF_TURN;
         flip_in = 1'b1;
      end else if (z_raw < -QUARTER_TURN) begin
         z_fold  = z_raw + HALF_TURN;
         flip_in = 1'b1;
      end
   end

   // Shifted operands for one rotation step
   assign x_sh  = x_ff >>> cmd.step;
   assign y_sh  = y_ff >>> cmd.step;
   assign x_neg = flip_ff ? -x_ff : x_ff;
   assign y_neg = flip_ff ? -y_ff : y_ff;

   // Shared multiplier: length times cosine, then length times sine
   assign len_sel  = (link_count_ff < LINK_IDX_W'(NUM_LINK_REGS)) ?
                     link_len_ff[link_count_ff] : '0;
   assign trig_sel = cmd.scale_x ? cos_ff : sin_ff;
   assign prod_in  = $signed({1'b0, len_sel}) * trig_sel;
   assign prod_q   = prod_ff[PROD_W-1:15];
   assign tip_step = {{(POS_W - (PROD_W - 15)){prod_q[PROD_W-16]}}, prod_q};

   // Chain ends on the marked joint or on the last configured link
   assign done = last_ff ||
                 (({1'b0, link_count_ff} + 4'd1) >= 4'(N_JOINTS));

   // Link length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINK_REGS; i++) begin
            link_len_ff[i] <= LINK_LEN_RESET;
         end
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(NUM_LINK_REGS))) begin
         link_len_ff[csr_index] <= csr_write_data;
      end
   end

   // Chain accumulators: update per request, clear at chain end
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_total_ff <= '0;
         tip_x_ff       <= '0;
         tip_y_ff       <= '0;
         link_count_ff  <= '0;
      end else begin
         if (cmd.start) begin
            angle_total_ff <= angle_in;
         end
         if (cmd.scale_y) begin
            tip_x_ff <= tip_x_ff + tip_step;
         end
         if (cmd.acc_y) begin
            tip_y_ff <= tip_y_ff + tip_step;
         end
         if (cmd.deliver) begin
            if (done) begin
               angle_total_ff <= '0;
               tip_x_ff       <= '0;
               tip_y_ff       <= '0;
               link_count_ff  <= '0;
            end else begin
               link_count_ff  <= link_count_ff + LINK_IDX_W'(1);
            end
         end
      end
   end

   // Rotation unit, trig registers, product and result payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff    <= CORDIC_X_INIT;
         y_ff    <= '0;
         z_ff    <= z_fold;
         flip_ff <= flip_in;
         last_ff <= last_joint;
      end else if (cmd.rotate) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - ATAN_TABLE[cmd.step];
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + ATAN_TABLE[cmd.step];
         end
      end
      if (cmd.trig) begin
         cos_ff <= sat_q15(x_neg);
         sin_ff <= sat_q15(y_neg);
      end
      if (cmd.scale_x || cmd.scale_y) begin
         prod_ff <= prod_in;
      end
      if (cmd.deliver) begin
         out_index_ff <= link_count_ff;
         out_x_ff     <= tip_x_ff;
         out_y_ff     <= tip_y_ff;
         out_done_ff  <= done;
      end
   end

   assign link_index = out_index_ff;
   assign end_x      = out_x_ff;
   assign end_y      = out_y_ff;
   assign chain_done = out_done_ff;

endmodule

// ===== sv/pafk_chk.sv =====
// Port-level checker for the planar arm block, bound to the top level.
// Depends only on the top level's ports.
module pafk_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         link_index,
   input logic signed [19:0] end_x,
   input logic signed [19:0] end_y,
   input logic               chain_done
);

   // Hold a stalled response and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(link_index) &&
         $stable(end_x) && $stable(end_y) && $stable(chain_done))
      else $error("stalled response changed");

   // Drop ready after a request is taken: one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   // Raise a response only if the block was not ready for a new request just before the rise
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while block was idle");

   // Link eight always closes the chain
   a_last_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (link_index == 3'd7) |-> chain_done)
      else $error("highest link did not end the chain");

endmodule

bind planar_arm_forward_kinematics pafk_chk u_pafk_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .link_index (rsp_ch.link_index),
   .end_x      (rsp_ch.end_x),
   .end_y      (rsp_ch.end_y),
   .chain_done (rsp_ch.chain_done)
);
